// ===== sv/response_frame_receiver_crc16_defines.svh =====
// assertion macros for the response frame receiver
`ifndef RESPONSE_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define RESPONSE_FRAME_RECEIVER_CRC16_DEFINES_SVH

// property checked on every clock edge outside reset
`define RFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define RFRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/rfrc_pkg.sv =====
// shared types, constants and crc table of the response frame receiver
`timescale 1ns / 1ps

package rfrc_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'hFF;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam int unsigned FRAME_XTRA = 7;
  localparam int unsigned POS_W      = 9;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_CRC    = 2'd1,
    VERDICT_OPCODE = 2'd2
  } verdict_e;

  // entry n is n * 0x1021, truncated to 16 bits
  localparam logic [15:0] CRC_NIB_TABLE [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063,
    16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
    16'h8108, 16'h9129, 16'hA14A, 16'hB16B,
    16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
  };

  typedef struct packed {
    logic             valid;
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_index;
    logic             last_byte;
    verdict_e         verdict;
  } result_t;

endpackage

// ===== sv/rfrc_crc_byte.sv =====
// one byte of the nibble-table crc-16, high nibble first
`timescale 1ns / 1ps

module rfrc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import rfrc_pkg::*;

  logic [15:0] mid;

  always_comb begin
    mid   = {crc_i[11:0], data_i[7:4]} ^ CRC_NIB_TABLE[crc_i[15:12]];
    crc_o = {mid[11:0], data_i[3:0]} ^ CRC_NIB_TABLE[mid[15:12]];
  end

endmodule

// ===== sv/rfrc_deframe.sv =====
// frame tracking state, crc accumulation and verdict for one byte per cycle while step_i is high
`timescale 1ns / 1ps

module rfrc_deframe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           expected_opcode_i,
  output rfrc_pkg::result_t    result_o
);
  import rfrc_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [7:0]       opcode_q, opcode_d;

  logic             active;
  logic [POS_W-1:0] pos;
  logic [15:0]      crc_cur;
  logic [15:0]      crc_next;
  logic [POS_W:0]   pos_w;
  logic [POS_W:0]   last_pos;
  logic             is_data;
  logic             is_crc_hi;
  logic             is_last;
  verdict_e         verdict;

  // a byte outside a frame only counts when it is a header
  assign active  = in_frame_q || (rx_byte_i == HDR_BYTE);
  assign pos     = in_frame_q ? pos_q : '0;
  assign crc_cur = in_frame_q ? crc_q : CRC_INIT;

  rfrc_crc_byte u_crc (
    .crc_i  (crc_cur),
    .data_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    len_d    = (pos == POS_W'(1)) ? rx_byte_i : len_q;
    opcode_d = (pos == POS_W'(2)) ? rx_byte_i : opcode_q;
    pos_w    = {1'b0, pos};
    last_pos = {{(POS_W - 7){1'b0}}, len_d} + (POS_W + 1)'(FRAME_XTRA - 1);

    is_data   = (pos != '0) && ((pos_w + (POS_W + 1)'(2)) <= last_pos);
    is_crc_hi = !is_data && (pos >= POS_W'(2)) && ((pos_w + (POS_W + 1)'(1)) == last_pos);
    is_last   = !is_data && !is_crc_hi && (pos >= POS_W'(2)) && (pos_w == last_pos);

    // crc is judged before the opcode
    if ((crc_hi_q != crc_cur[15:8]) || (rx_byte_i != crc_cur[7:0])) begin
      verdict = VERDICT_CRC;
    end else if (opcode_d != expected_opcode_i) begin
      verdict = VERDICT_OPCODE;
    end else begin
      verdict = VERDICT_OK;
    end

    crc_d      = is_data ? crc_next : crc_cur;
    crc_hi_d   = is_crc_hi ? rx_byte_i : crc_hi_q;
    in_frame_d = active && !is_last;
    pos_d      = is_last ? '0 : pos + POS_W'(1);

    result_o.valid      = step_i && active;
    result_o.frame_byte = rx_byte_i;
    result_o.byte_index = pos;
    result_o.last_byte  = is_last;
    result_o.verdict    = is_last ? verdict : VERDICT_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      crc_q      <= CRC_INIT;
      crc_hi_q   <= '0;
      opcode_q   <= '0;
    end else if (step_i && active) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      opcode_q   <= opcode_d;
    end
  end

endmodule

// ===== sv/response_frame_receiver_crc16.sv =====
// top level of the response frame receiver with nibble-table crc-16
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, rx_byte_i         | in
//  output  | out_valid_o, out_stall_i, frame_byte_o,   | out
//          | byte_index_o, last_byte_o, verdict_o      |
//  config  | cfg_valid_i, cfg_ready_o,                 | in
//          | expected_opcode_i                         |
//
// one item per cycle sustained while out_stall_i is low; each item passes through
// the input register and the result register around the deframer
// reset clears frame state, crc to 0xffff and the expected opcode to zero
// out_stall_i holds the result register; the input register keeps taking
// items until it is full too, then in_stall_o rises
`timescale 1ns / 1ps

module response_frame_receiver_crc16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [8:0] byte_index_o,
  output logic       last_byte_o,
  output logic [1:0] verdict_o,
  // config channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] expected_opcode_i
);
  import rfrc_pkg::*;

  `include "response_frame_receiver_crc16_defines.svh"

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  // result register
  logic       out_valid_q;
  result_t    out_q;
  // expected opcode register
  logic [7:0] exp_op_q;

  logic       step;
  logic       in_accept;
  result_t    res;

  // the deframer runs when the input register holds an item and the result register is free or drains this cycle
  assign step      = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_op_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_op_q <= expected_opcode_i;
    end
  end

  rfrc_deframe u_deframe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (in_byte_q),
    .expected_opcode_i (exp_op_q),
    .result_o          (res)
  );

  // result register: ignored bytes leave it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_q.frame_byte;
  assign byte_index_o = out_q.byte_index;
  assign last_byte_o  = out_q.last_byte;
  assign verdict_o    = out_q.verdict;

  // a verdict other than ok only ever comes with the last byte
  `RFRC_ASSERT(a_verdict_on_last, (out_valid_o && !last_byte_o) |-> (verdict_o == VERDICT_OK), "verdict without last byte")
  // the shortest frame ends at position six, the longest at 261
  `RFRC_ASSERT(a_last_pos_range, (out_valid_o && last_byte_o) |-> ((byte_index_o >= 9'd6) && (byte_index_o <= 9'd261)), "last byte at impossible position")
  // input stalls only while an item waits in the input register
  `RFRC_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> in_valid_q, "stall with empty input register")
  // a result that was stalled is still offered in the next cycle
  `RFRC_ASSERT(a_result_held, (out_valid_o && out_stall_i) |=> out_valid_o, "stalled result dropped")

endmodule
